>>> rtl/core/lcdf_pkg.sv
// ----------------------------------------------------------------------------
// lcdf_pkg: shared types and constants for the character LCD framer
// Operation codes, register indexes, word bit positions, fixed command
// bytes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package lcdf_pkg;

  // operation codes on the command field
  typedef enum logic [1:0] {
    CMD_SEND_BYTE  = 2'd0,
    CMD_PRINT_CHAR = 2'd1,
    CMD_SET_CURSOR = 2'd2,
    CMD_INIT       = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMN_COUNT    = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT      = 2'd1;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd2;

  // register reset values
  localparam logic [6:0] COLUMN_COUNT_RST    = 7'd16;
  localparam logic [2:0] LINE_COUNT_RST      = 3'd2;
  localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0C;

  // shift word control bits
  localparam logic [7:0] WORD_EN = 8'h40;
  localparam logic [7:0] WORD_RS = 8'h20;

  // fixed display command bytes
  localparam logic [7:0] LINE1_ADDR    = 8'h80;
  localparam logic [7:0] LINE2_ADDR    = 8'hC0;
  localparam logic [7:0] FUNCTION_SET  = 8'h28;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] WAKE_PAIR     = 8'h33; // two wake-up nibbles of 3
  localparam logic [7:0] MODE_PAIR     = 8'h32; // third wake-up nibble, then 4-bit mode

  // byte queue depth (init sends five bytes)
  localparam int QUEUE_DEPTH = 5;
  localparam int QCNT_W      = 3;

  // word phase inside one nibble
  localparam logic [1:0] PH_STROBE = 2'd0;
  localparam logic [1:0] PH_HOLD   = 2'd1;
  localparam logic [1:0] PH_IDLE   = 2'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic load;     // take the request on the input channel
    logic advance;  // current word was taken
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_words;  // request being loaded produces no words
    logic last_word; // current word ends the run
  } ctrl_status_t;

endpackage

>>> rtl/core/lcdf_ctrl.sv
// ----------------------------------------------------------------------------
// lcdf_ctrl: controller for the character LCD framer
// Idles until a request arrives, then, unless it produces no words, steps
// the datapath one word per accepted output until the run ends.
// ----------------------------------------------------------------------------
module lcdf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  lcdf_pkg::ctrl_status_t status,
  output lcdf_pkg::ctrl_cmd_t    cmd
);

  lcdf_pkg::state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pick next state and drive datapath commands
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state)
      lcdf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.no_words) state_next = lcdf_pkg::ST_EMIT;
        end
      end
      lcdf_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.advance = 1'b1;
          if (status.last_word) state_next = lcdf_pkg::ST_IDLE;
        end
      end
      default: state_next = lcdf_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/lcdf_datapath.sv
// ----------------------------------------------------------------------------
// lcdf_datapath: byte queue, cursor state and word builder
// Plans the bytes of a request on load, keeps the cursor and the
// configuration registers, and turns the queue head into shift words.
// ----------------------------------------------------------------------------
module lcdf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic [1:0]            command,
  input  logic [7:0]            data_byte,
  input  logic [2:0]            cursor_line,
  input  logic [5:0]            cursor_column,
  input  lcdf_pkg::ctrl_cmd_t    cmd,
  output lcdf_pkg::ctrl_status_t status,
  output logic [7:0]            shift_word,
  output logic                  last
);

  localparam int QD = lcdf_pkg::QUEUE_DEPTH;
  localparam int CW = lcdf_pkg::QCNT_W;

  // configuration
  logic [6:0] column_count;
  logic [2:0] line_count;
  logic [7:0] display_control;

  // cursor
  logic [2:0] cur_line;
  logic [6:0] cur_col;

  // byte queue: {rs, byte}, head at entry 0
  logic [8:0]    queue [QD];
  logic [CW-1:0] count;
  logic [1:0]    phase;
  logic          half;

  // load plan
  logic [8:0]    plan [QD];
  logic [CW-1:0] plan_count;
  logic [2:0]    plan_line;
  logic [6:0]    plan_col;

  // print wrap terms
  logic [7:0] col_inc;
  logic       wrap_col;
  logic [3:0] line_inc;
  logic       wrap_line;
  logic       move_emit;
  logic [7:0] move_byte;
  logic [7:0] set_byte;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= lcdf_pkg::COLUMN_COUNT_RST;
      line_count      <= lcdf_pkg::LINE_COUNT_RST;
      display_control <= lcdf_pkg::DISPLAY_CONTROL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcdf_pkg::REG_COLUMN_COUNT:    column_count    <= cfg_data[6:0];
        lcdf_pkg::REG_LINE_COUNT:      line_count      <= cfg_data[2:0];
        lcdf_pkg::REG_DISPLAY_CONTROL: display_control <= cfg_data;
        default: ;
      endcase
    end
  end

  // work out cursor wrap for a printed character
  always_comb begin
    col_inc   = {1'b0, cur_col} + 8'd1;
    wrap_col  = col_inc >= {1'b0, column_count};
    line_inc  = wrap_col ? ({1'b0, cur_line} + 4'd1) : {1'b0, cur_line};
    wrap_line = line_inc > {1'b0, line_count};
    move_emit = wrap_col && (line_inc == 4'd1 || line_inc == 4'd2);
    move_byte = (line_inc == 4'd1) ? lcdf_pkg::LINE1_ADDR : lcdf_pkg::LINE2_ADDR;
    set_byte  = ((cursor_line == 3'd1) ? lcdf_pkg::LINE1_ADDR : lcdf_pkg::LINE2_ADDR)
                + {2'b00, cursor_column};
  end

  // plan the bytes and the new cursor of the incoming request
  always_comb begin
    for (int i = 0; i < QD; i++) plan[i] = '0;
    plan_count = '0;
    plan_line  = cur_line;
    plan_col   = cur_col;
    unique case (lcdf_pkg::cmd_t'(command))
      lcdf_pkg::CMD_SEND_BYTE: begin
        plan[0]    = {1'b0, data_byte};
        plan_count = CW'(1);
      end
      lcdf_pkg::CMD_PRINT_CHAR: begin
        plan[0] = {1'b1, data_byte};
        if (move_emit) begin
          plan[1] = {1'b0, move_byte};
          plan[2] = {1'b0, lcdf_pkg::LINE1_ADDR};
        end else begin
          plan[1] = {1'b0, lcdf_pkg::LINE1_ADDR};
        end
        plan_count = CW'(1) + CW'(move_emit) + CW'(wrap_line);
        if (wrap_line) begin
          plan_line = 3'd1;
          plan_col  = '0;
        end else if (wrap_col) begin
          plan_line = line_inc[2:0];
          plan_col  = '0;
        end else begin
          plan_col  = col_inc[6:0];
        end
      end
      lcdf_pkg::CMD_SET_CURSOR: begin
        plan[0]    = {1'b0, set_byte};
        plan_count = (cursor_line == 3'd1 || cursor_line == 3'd2) ? CW'(1) : CW'(0);
        plan_line  = cursor_line;
        plan_col   = {1'b0, cursor_column};
      end
      lcdf_pkg::CMD_INIT: begin
        plan[0]    = {1'b0, lcdf_pkg::WAKE_PAIR};
        plan[1]    = {1'b0, lcdf_pkg::MODE_PAIR};
        plan[2]    = {1'b0, lcdf_pkg::FUNCTION_SET};
        plan[3]    = {1'b0, display_control};
        plan[4]    = {1'b0, lcdf_pkg::CLEAR_DISPLAY};
        plan_count = CW'(QD);
        plan_line  = 3'd1;
        plan_col   = '0;
      end
      default: ;
    endcase
  end

  // load the plan, then advance phase, nibble and queue per taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line <= 3'd1;
      cur_col  <= '0;
      count    <= '0;
      phase    <= lcdf_pkg::PH_STROBE;
      half     <= 1'b0;
    end else if (cmd.load) begin
      cur_line <= plan_line;
      cur_col  <= plan_col;
      count    <= plan_count;
      phase    <= lcdf_pkg::PH_STROBE;
      half     <= 1'b0;
    end else if (cmd.advance) begin
      if (phase == lcdf_pkg::PH_IDLE) begin
        phase <= lcdf_pkg::PH_STROBE;
        half  <= ~half;
        if (half) count <= count - CW'(1);
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // queue payload: fill on load, shift toward the head after each byte
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < QD; i++) queue[i] <= plan[i];
    end else if (cmd.advance && phase == lcdf_pkg::PH_IDLE && half) begin
      for (int i = 0; i < QD - 1; i++) queue[i] <= queue[i+1];
    end
  end

  // build the word from the queue head
  logic [3:0] nibble;
  logic [7:0] base;
  always_comb begin
    nibble = half ? queue[0][3:0] : queue[0][7:4];
    base   = {4'b0000, nibble} | (queue[0][8] ? lcdf_pkg::WORD_RS : 8'h00);
    unique case (phase)
      lcdf_pkg::PH_STROBE: shift_word = base | lcdf_pkg::WORD_EN;
      lcdf_pkg::PH_HOLD:   shift_word = base;
      default:             shift_word = 8'h00;
    endcase
  end

  assign status.last_word = (count == CW'(1)) && half && (phase == lcdf_pkg::PH_IDLE);
  assign status.no_words  = (plan_count == '0);
  assign last             = status.last_word;

endmodule

>>> rtl/core/char_lcd_shift_register_framer.sv
// Start: first word of a request is shown the cycle after it is taken.
// Throughput: six words per byte, one per cycle without output stall; a set cursor to a
// line other than 1 or 2 sends no words. Words come from the byte queue sequencer, which
// runs one request at a time.
// Reset: synchronous, active high; registers to 16 columns, 2 lines, control 0x0C,
// cursor to line 1 column 0, no run in progress.
// ----------------------------------------------------------------------------
// char_lcd_shift_register_framer: character LCD framer, 4-bit mode
// Turns display operations into parallel words for an output shift register.
// ----------------------------------------------------------------------------
module char_lcd_shift_register_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  input  logic [2:0] cursor_line,
  input  logic [5:0] cursor_column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] shift_word,
  output logic       last
);

  lcdf_pkg::ctrl_cmd_t    cmd;
  lcdf_pkg::ctrl_status_t status;

  // sequence requests and words
  lcdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // plan bytes, keep cursor, build words
  lcdf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .data_byte     (data_byte),
    .cursor_line   (cursor_line),
    .cursor_column (cursor_column),
    .cmd           (cmd),
    .status        (status),
    .shift_word    (shift_word),
    .last          (last)
  );

endmodule

>>> rtl/core/lcdf_checker.sv
// ----------------------------------------------------------------------------
// lcdf_checker: port-level checks for the character LCD framer
// Watches the handshakes and word format on the top level's ports.
// ----------------------------------------------------------------------------
module lcdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] shift_word,
  input logic       last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shift_word) && $stable(last))
    else $error("stalled output word changed");

  // no request taken while a run is in progress
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during a run");

  // run ends after its last word
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("words after last");

  // unused word bits stay clear
  a_word_format: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shift_word[7] == 1'b0 && shift_word[4] == 1'b0)
    else $error("reserved word bit set");

endmodule

bind char_lcd_shift_register_framer lcdf_checker u_lcdf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .shift_word (shift_word),
  .last       (last)
);

>>> tb/sv/lcdf_word_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdf_word_monitor: word stream predictor and comparator for the LCD framer
// Watches the register port and both channels. It keeps its own copy of the
// cursor and the registers, builds the word run of every accepted request and
// compares each accepted output word, oldest first, against that run.
// ----------------------------------------------------------------------------
module lcdf_word_monitor
  import lcdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  input  logic [2:0] cursor_line,
  input  logic [5:0] cursor_column,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] shift_word,
  input  logic       last,
  output int         failures,
  output int         pending
);

  // mirrored registers and cursor
  logic [6:0] col_limit;
  logic [2:0] line_limit;
  logic [7:0] disp_ctrl;
  logic [2:0] cur_line;
  logic [6:0] cur_col;

  // words still owed by the block, with their end-of-run flags
  logic [7:0] word_q[$];
  logic       last_q[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report(input string field, input int want, input int got);
    begin
      failures++;
      // keep the log short on a badly broken block
      if (failures <= 100)
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  task automatic put_word(input logic [7:0] w);
    begin
      word_q.push_back(w);
      last_q.push_back(1'b0);
    end
  endtask

  // one nibble: strobe with EN, hold without EN, then an all-zero word
  task automatic put_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] w;
    begin
      w = {4'h0, nib} | WORD_EN | (rs ? WORD_RS : 8'h00);
      put_word(w);
      put_word(w & ~WORD_EN);
      put_word(8'h00);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic rs);
    begin
      put_nibble(b[7:4], rs);
      put_nibble(b[3:0], rs);
    end
  endtask

  // store the cursor; only lines 1 and 2 get an address command
  task automatic place_cursor(input int ln, input int cl);
    logic [7:0] col_byte;
    begin
      cur_line = ln[2:0];
      cur_col  = cl[6:0];
      col_byte = cl[7:0];
      if (ln == 1)
        put_byte(LINE1_ADDR + col_byte, 1'b0);
      else if (ln == 2)
        put_byte(LINE2_ADDR + col_byte, 1'b0);
    end
  endtask

  // build the whole word run of one request and mark its final word
  task automatic frame_request(input logic [1:0] op, input logic [7:0] ch,
                               input logic [2:0] tl, input logic [5:0] tc);
    int base;
    int next_col;
    int next_line;
    begin
      base = word_q.size();
      case (cmd_t'(op))
        CMD_SEND_BYTE: begin
          put_byte(ch, 1'b0);
        end
        CMD_PRINT_CHAR: begin
          next_col  = cur_col + 1;
          next_line = cur_line;
          put_byte(ch, 1'b1);
          if (next_col >= col_limit) begin
            next_line = cur_line + 1;
            place_cursor(next_line, 0);
          end else begin
            cur_col = next_col[6:0];
          end
          // past the last line: back to the top left
          if (next_line > line_limit)
            place_cursor(1, 0);
        end
        CMD_SET_CURSOR: begin
          place_cursor(tl, tc);
        end
        default: begin
          cur_line = 3'd1;
          cur_col  = 7'd0;
          // wake-up nibbles 3, 3, 3, then 2 to enter 4-bit mode
          put_byte(WAKE_PAIR, 1'b0);
          put_byte(MODE_PAIR, 1'b0);
          put_byte(FUNCTION_SET, 1'b0);
          put_byte(disp_ctrl, 1'b0);
          put_byte(CLEAR_DISPLAY, 1'b0);
        end
      endcase
      if (word_q.size() > base)
        last_q[last_q.size() - 1] = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    logic [7:0] want_word;
    logic       want_last;
    if (rst) begin
      col_limit  = COLUMN_COUNT_RST;
      line_limit = LINE_COUNT_RST;
      disp_ctrl  = DISPLAY_CONTROL_RST;
      cur_line   = 3'd1;
      cur_col    = 7'd0;
      word_q.delete();
      last_q.delete();
      pending <= 0;
    end else begin
      // track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_COLUMN_COUNT:    col_limit  = cfg_data[6:0];
          REG_LINE_COUNT:      line_limit = cfg_data[2:0];
          REG_DISPLAY_CONTROL: disp_ctrl  = cfg_data;
          default: ;
        endcase
      end
      // predict the run of each accepted request
      if (in_valid && !in_stall)
        frame_request(command, data_byte, cursor_line, cursor_column);
      // compare each accepted word with the oldest one owed
      if (out_valid && !out_stall) begin
        if (word_q.size() == 0) begin
          report("unrequested word", 0, shift_word);
        end else begin
          want_word = word_q.pop_front();
          want_last = last_q.pop_front();
          if (shift_word !== want_word)
            report("shift_word", want_word, shift_word);
          if (last !== want_last)
            report("last", want_last, last);
        end
      end
      pending <= word_q.size();
    end
  end

endmodule

>>> tb/sv/tb_char_lcd_shift_register_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_shift_register_framer: stimulus and verdict for the LCD framer
// Runs directed requests over the cursor wraps and register extremes, then
// random phases under changing settings, with random gaps and output stall.
// Word checking is done by the monitor instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_char_lcd_shift_register_framer;
  import lcdf_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [2:0] cursor_line;
  logic [5:0] cursor_column;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] shift_word;
  logic       last;

  int failures;
  int pending;

  // no gaps and no stall while set
  bit calm;
  int stall_run;
  int phase_lines;

  char_lcd_shift_register_framer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .data_byte     (data_byte),
    .cursor_line   (cursor_line),
    .cursor_column (cursor_column),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .shift_word    (shift_word),
    .last          (last)
  );

  lcdf_word_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .data_byte     (data_byte),
    .cursor_line   (cursor_line),
    .cursor_column (cursor_column),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .shift_word    (shift_word),
    .last          (last),
    .failures      (failures),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // end a hung run
  initial begin
    #(30_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (calm || r < 55)
        pick_gap = 0;
      else if (r < 90)
        pick_gap = $urandom_range(1, 3);
      else
        pick_gap = $urandom_range(8, 40);
    end
  endfunction

  // random output stall in runs
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if (calm || $urandom_range(0, 1)) begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b1;
      stall_run = pick_gap();
    end
  end

  // offer one request and hold it until taken
  task automatic issue(input cmd_t op, input logic [7:0] ch,
                       input logic [2:0] tl, input logic [5:0] tc);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      command       <= op;
      data_byte     <= ch;
      cursor_line   <= tl;
      cursor_column <= tc;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  // hold off until every owed word is out and the block has gone quiet
  task automatic settle();
    begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end
  endtask

  // write all three registers, with random bits above the column and line fields
  task automatic configure(input logic [6:0] cc, input logic [2:0] lc, input logic [7:0] dc);
    logic [7:0] pad;
    begin
      pad = $urandom;
      phase_lines = lc;
      cfg_write <= 1'b1;
      cfg_index <= REG_COLUMN_COUNT;
      cfg_data  <= {pad[0], cc};
      @(posedge clk);
      cfg_index <= REG_LINE_COUNT;
      cfg_data  <= {pad[5:1], lc};
      @(posedge clk);
      cfg_index <= REG_DISPLAY_CONTROL;
      cfg_data  <= dc;
      @(posedge clk);
      cfg_write <= 1'b0;
    end
  endtask

  // one random request, weighted toward printing and cursor moves
  task automatic random_request();
    int r;
    logic [7:0] ch;
    logic [2:0] tl;
    logic [5:0] tc;
    begin
      r  = $urandom_range(0, 99);
      ch = $urandom;
      tl = $urandom;
      tc = $urandom;
      if (r < 45) begin
        issue(CMD_PRINT_CHAR, ch, tl, tc);
      end else if (r < 65) begin
        issue(CMD_SEND_BYTE, ch, tl, tc);
      end else if (r < 90) begin
        if ($urandom_range(0, 4) != 0 && phase_lines > 0)
          tl = $urandom_range(1, (phase_lines > 4) ? 4 : phase_lines);
        if ($urandom_range(0, 1))
          tc = $urandom_range(0, 7);
        issue(CMD_SET_CURSOR, ch, tl, tc);
      end else begin
        issue(CMD_INIT, ch, tl, tc);
      end
    end
  endtask

  initial begin
    logic [6:0] cc;
    logic [2:0] lc;
    int r;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_COLUMN_COUNT;
    cfg_data      = 8'h00;
    in_valid      = 1'b0;
    command       = CMD_SEND_BYTE;
    data_byte     = 8'h00;
    cursor_line   = 3'd1;
    cursor_column = 6'd0;
    out_stall     = 1'b0;
    stall_run     = 0;
    calm          = 1'b0;
    phase_lines   = LINE_COUNT_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, field extremes, every operation
    issue(CMD_INIT, 8'hFF, 3'd7, 6'd63);
    issue(CMD_SEND_BYTE, 8'h00, 3'd0, 6'd0);
    issue(CMD_SEND_BYTE, 8'hFF, 3'd7, 6'd63);
    issue(CMD_PRINT_CHAR, 8'h41, 3'd0, 6'd0);
    issue(CMD_SET_CURSOR, 8'hFF, 3'd1, 6'd0);
    issue(CMD_SET_CURSOR, 8'h00, 3'd2, 6'd63);
    // line beyond 2 stores the cursor silently; printing there wraps home
    issue(CMD_SET_CURSOR, 8'h00, 3'd3, 6'd5);
    issue(CMD_PRINT_CHAR, 8'h5A, 3'd0, 6'd0);
    // line 0 at the last column wraps onto line 1
    issue(CMD_SET_CURSOR, 8'h00, 3'd0, 6'd15);
    issue(CMD_PRINT_CHAR, 8'h30, 3'd0, 6'd0);
    // line 7 plus one still counts as past the last line
    issue(CMD_SET_CURSOR, 8'h00, 3'd7, 6'd15);
    issue(CMD_PRINT_CHAR, 8'h31, 3'd0, 6'd0);
    // column wrap from line 1 to line 2, then from line 2 back home
    issue(CMD_SET_CURSOR, 8'h00, 3'd1, 6'd15);
    issue(CMD_PRINT_CHAR, 8'h32, 3'd0, 6'd0);
    issue(CMD_SET_CURSOR, 8'h00, 3'd2, 6'd15);
    issue(CMD_PRINT_CHAR, 8'h33, 3'd0, 6'd0);
    settle();

    // zero columns and lines: every character wraps
    configure(7'd0, 3'd0, 8'h00);
    issue(CMD_PRINT_CHAR, 8'hAA, 3'd0, 6'd0);
    issue(CMD_PRINT_CHAR, 8'h55, 3'd0, 6'd0);
    issue(CMD_INIT, 8'h00, 3'd0, 6'd0);
    settle();

    // largest settings
    configure(7'd127, 3'd7, 8'hFF);
    issue(CMD_INIT, 8'h00, 3'd0, 6'd0);
    issue(CMD_SET_CURSOR, 8'h00, 3'd4, 6'd63);
    issue(CMD_PRINT_CHAR, 8'h7E, 3'd0, 6'd0);
    settle();

    // single column on a single line
    configure(7'd1, 3'd1, 8'h0F);
    issue(CMD_PRINT_CHAR, 8'h21, 3'd0, 6'd0);
    issue(CMD_PRINT_CHAR, 8'h22, 3'd0, 6'd0);
    settle();

    // widest usable display: last column of line 4 wraps home
    configure(7'd64, 3'd4, 8'hC3);
    issue(CMD_SET_CURSOR, 8'h00, 3'd4, 6'd63);
    issue(CMD_PRINT_CHAR, 8'h23, 3'd0, 6'd0);
    settle();

    // random phases, each under fresh settings
    for (int phase = 0; phase < 8; phase++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        cc = $urandom_range(1, 8);
      else if (r < 80)
        cc = $urandom_range(9, 64);
      else if (r < 90)
        cc = 7'd0;
      else
        cc = $urandom_range(65, 127);
      lc = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      configure(cc, lc, $urandom);
      calm = (phase % 3 == 2);
      for (int n = 0; n < 50; n++) begin
        random_request();
        // now and then drain completely before going on
        if ($urandom_range(0, 49) == 0)
          settle();
      end
      settle();
      calm = 1'b0;
    end

    if (failures == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
